[sv/brv_pkg.sv]
// ----------------------------------------------------------------------------
// brv_pkg: shared types and constants of the bitmap row run vectorizer
// command codes, field widths and the record passed from front to back
// ----------------------------------------------------------------------------
package brv_pkg;

	localparam int unsigned PIX_W         = 8;
	localparam int unsigned ROW_W         = 14;
	localparam int unsigned AMT_W         = 13;
	localparam int unsigned EVT_W         = PIX_W + 1;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned MAX_ROW_BYTES = 512;
	localparam int unsigned QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		CMD_ABS_MOVE = 2'd0,
		CMD_REL_MOVE = 2'd1,
		CMD_REL_DRAW = 2'd2
	} cmd_t;

	// one classified byte: edge events, pixels in column order, first column
	typedef struct packed {
		logic [EVT_W-1:0] events;
		logic [PIX_W-1:0] ink;
		logic [AMT_W-1:0] base;
		logic [ROW_W-1:0] row;
		logic             at_end;
	} byte_rec_t;

	// one vector command
	typedef struct packed {
		cmd_t             command;
		logic [AMT_W-1:0] amount;
		logic [ROW_W-1:0] row;
		logic             last;
	} result_t;

endpackage

[sv/brv_fifo.sv]
// ----------------------------------------------------------------------------
// brv_fifo: small register queue
// first-in first-out store with the head shown combinationally
// ----------------------------------------------------------------------------
module brv_fifo
	import brv_pkg::*;
#(
	parameter type         T     = byte_rec_t,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     din,
	input  logic rd_en,
	output T     dout,
	output logic full,
	output logic empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	T                   entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign dout  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("write to a full queue");

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty))
		else $error("queue flagged full and empty at once");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

[sv/brv_front.sv]
// ----------------------------------------------------------------------------
// brv_front: byte classifier
// tracks the column and open run, marks every run edge of an accepted byte
// ----------------------------------------------------------------------------
module brv_front
	import brv_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = brv_pkg::MAX_ROW_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [PIX_W-1:0] pixel_byte,
	input  logic [ROW_W-1:0] row_number,
	input  logic             row_end,
	output byte_rec_t        rec
);

	localparam int unsigned COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

	logic [COL_W-1:0] byte_col_q;
	logic             inside_q;
	logic [PIX_W-1:0] ink;
	logic             at_end;
	logic [COL_W+2:0] col_wide;

	// pixels in column order, leftmost first
	always_comb begin
		for (int i = 0; i < PIX_W; i++) begin
			ink[i] = pixel_byte[PIX_W-1-i];
		end
	end

	assign at_end   = row_end || (byte_col_q == COL_W'(MAX_ROW_BYTES - 1));
	assign col_wide = {byte_col_q, 3'b000};

	// edge events, plus a close at the row end
	always_comb begin
		rec.events[0] = ink[0] ^ inside_q;
		for (int i = 1; i < PIX_W; i++) begin
			rec.events[i] = ink[i] ^ ink[i-1];
		end
		rec.events[PIX_W] = at_end && ink[PIX_W-1];
		rec.ink    = ink;
		rec.base   = AMT_W'(col_wide);
		rec.row    = row_number;
		rec.at_end = at_end;
	end

	// row position and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_col_q <= '0;
			inside_q   <= 1'b0;
		end else if (accept) begin
			if (at_end) begin
				byte_col_q <= '0;
				inside_q   <= 1'b0;
			end else begin
				byte_col_q <= byte_col_q + 1'b1;
				inside_q   <= ink[PIX_W-1];
			end
		end
	end

	// checks
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && at_end |=> byte_col_q == '0 && !inside_q)
		else $error("row state not cleared after row end");

endmodule

[sv/brv_back.sv]
// ----------------------------------------------------------------------------
// brv_back: command emitter
// walks the edge events of the head record; while the result queue has room, one vector command per cycle
// ----------------------------------------------------------------------------
module brv_back
	import brv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  byte_rec_t head,
	input  logic      head_valid,
	output logic      head_rd,
	input  logic      out_full,
	output logic      out_wr,
	output result_t   res
);

	logic [EVT_W-1:0] done_q;
	logic [AMT_W-1:0] eol_q;
	logic             first_q;

	logic [EVT_W-1:0] remain;
	logic [EVT_W-1:0] pick;
	logic [IDX_W-1:0] idx;
	logic             only_one;
	logic             is_move;
	logic [AMT_W-1:0] col;

	assign remain   = head.events & ~done_q;
	assign pick     = remain & (~remain + 1'b1);
	assign only_one = (remain & (remain - 1'b1)) == '0;

	// lowest pending event
	always_comb begin
		idx = '0;
		for (int i = EVT_W - 1; i >= 0; i--) begin
			if (remain[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	assign is_move = (idx < IDX_W'(PIX_W)) && head.ink[idx[2:0]];
	assign col     = head.base + AMT_W'(idx);

	// handshake with both queues
	always_comb begin
		if (remain == '0) begin
			out_wr  = 1'b0;
			head_rd = head_valid;
		end else begin
			out_wr  = head_valid && !out_full;
			head_rd = head_valid && !out_full && only_one;
		end
	end

	// result fields
	always_comb begin
		if (!is_move) begin
			res.command = CMD_REL_DRAW;
		end else if (first_q) begin
			res.command = CMD_ABS_MOVE;
		end else begin
			res.command = CMD_REL_MOVE;
		end
		res.amount = (is_move && first_q) ? col : col - eol_q;
		res.row    = head.row;
		res.last   = only_one;
	end

	// progress through the record and run end tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			eol_q   <= '0;
			first_q <= 1'b1;
		end else begin
			if (head_rd) begin
				done_q <= '0;
			end else if (out_wr) begin
				done_q <= done_q | pick;
			end
			if (head_rd && head.at_end) begin
				eol_q   <= '0;
				first_q <= 1'b1;
			end else if (out_wr) begin
				eol_q <= col;
				if (is_move) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	// checks
	a_single_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> $onehot(pick) && !out_full)
		else $error("emit without a single pending event or space");

	a_abs_only_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr && res.command == CMD_ABS_MOVE |=> !first_q || $past(head_rd && head.at_end))
		else $error("absolute move did not end the first run state");

endmodule

[sv/bitmap_row_run_vectorizer.sv]
// The first result of a byte passes through the record queue and then the result queue
// before it reaches the result ports.
// The front takes one byte per cycle while the back end keeps up. The back end gives one
// command per cycle while the result queue has room, and holds a byte until its last result is out.
// Two-entry queues sit between front and back and on the result side.
// Reset: asynchronous, active low; clears both queues and starts a fresh row.
// ----------------------------------------------------------------------------
// bitmap_row_run_vectorizer: top level
// turns runs of set pixels in a bitmap row into move and draw commands
// ----------------------------------------------------------------------------
module bitmap_row_run_vectorizer
	import brv_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = brv_pkg::MAX_ROW_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [PIX_W-1:0] pixel_byte,
	input  logic [ROW_W-1:0] row_number,
	input  logic             row_end,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       command,
	output logic [AMT_W-1:0] amount,
	output logic [ROW_W-1:0] row_out,
	output logic             last
);

	byte_rec_t rec;
	byte_rec_t head;
	logic      accept;
	logic      mid_empty;
	logic      head_rd;
	logic      out_wr;
	logic      out_full;
	result_t   res;
	result_t   res_head;

	assign accept = push && !full;

	// front: classify accepted bytes
	brv_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel_byte(pixel_byte),
		.row_number(row_number),
		.row_end   (row_end),
		.rec       (rec)
	);

	// record queue between front and back
	brv_fifo #(
		.T    (byte_rec_t),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (accept),
		.din   (rec),
		.rd_en (head_rd),
		.dout  (head),
		.full  (full),
		.empty (mid_empty)
	);

	// back: emit commands
	brv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(!mid_empty),
		.head_rd   (head_rd),
		.out_full  (out_full),
		.out_wr    (out_wr),
		.res       (res)
	);

	// result queue
	brv_fifo #(
		.T    (result_t),
		.DEPTH(QUEUE_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (out_wr),
		.din   (res),
		.rd_en (pop),
		.dout  (res_head),
		.full  (out_full),
		.empty (empty)
	);

	assign command = res_head.command;
	assign amount  = res_head.amount;
	assign row_out = res_head.row;
	assign last    = res_head.last;

endmodule
